// ----- design/npc_pkg.sv -----
// ----------------------------------------------------------------------------
// npc_pkg
// Shared constants, types and codes of the nearest palette colour search.
// ----------------------------------------------------------------------------
package npc_pkg;

    // Palette storage
    localparam int PALETTE_DEPTH = 256;
    localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

    // Field widths
    localparam int CHAN_W   = 8;
    localparam int ENTRY_W  = 8;
    localparam int IDX_W    = 8;
    localparam int SIZE_W   = 9;
    localparam int WORD_W   = 3 * CHAN_W;
    localparam int TDATA_W  = 32;
    // 3 * 255^2 = 195075 fits in 18 bits
    localparam int DIST_W   = 18;

    localparam int SIZE_RESET = 16;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [SIZE_W-1:0]  t_size;
    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [DIST_W-1:0]  t_dist;

    // Starting best distance: above any real distance
    localparam t_dist DIST_START = '1;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    // One input item
    typedef struct packed {
        t_cmd                 cmd;
        logic [ENTRY_W-1:0]   entry;
        t_chan                red;
        t_chan                green;
        t_chan                blue;
    } t_item;

    // Registered distance of one palette entry
    typedef struct packed {
        logic  vld;
        t_addr idx;
        t_dist distance;
    } t_dist_res;

    // Finished result handed to the output register
    typedef struct packed {
        logic vld;
        t_idx idx;
    } t_result;

endpackage

// ----- design/nearest_palette_color.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color
// Maps RGB pixels to the nearest entry of a loadable 256-colour palette.
// ----------------------------------------------------------------------------
// A transaction with tuser = 0 loads one palette entry (entry index in tdata
// bits 7:0) and produces no result. A transaction with tuser = 1 classifies
// a pixel: entries 0 .. min(palette_size, 256)-1 are read from the palette
// RAM one per cycle through its single read port and the index of the
// nearest one is returned, lowest index on ties. An exact match stops the
// scan early, and palette_size 0 answers index 0. One pixel is searched at
// a time; the finished index sits in an output register, so the next
// transaction is taken while it waits. Palette entries must be loaded before
// they are searched. palette_size resets to 16 and is written through the
// cfg channel; the user must write it only while the block is idle, which
// the block itself does not enforce.
// ----------------------------------------------------------------------------
module nearest_palette_color (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Pixel / load stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [npc_pkg::TDATA_W-1:0] s_axis_tdata,
    // command[0]
    input  logic [0:0]                  s_axis_tuser,
    // Result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // color_index[7:0]
    output logic [npc_pkg::IDX_W-1:0]   m_axis_tdata,
    // Configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  npc_pkg::t_size              i_cfg_data
);

    npc_pkg::t_size   r_palette_size;
    logic             r_out_vld;
    npc_pkg::t_idx    r_out_idx;
    npc_pkg::t_item   item;
    npc_pkg::t_result res;
    logic             out_free;

    // Unpack the input transaction
    assign item.cmd   = npc_pkg::t_cmd'(s_axis_tuser[0]);
    assign item.entry = s_axis_tdata[7:0];
    assign item.red   = s_axis_tdata[15:8];
    assign item.green = s_axis_tdata[23:16];
    assign item.blue  = s_axis_tdata[31:24];

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_size <= npc_pkg::t_size'(npc_pkg::SIZE_RESET);
        end else if (i_cfg_valid) begin
            r_palette_size <= i_cfg_data;
        end
    end

    npc_search u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item_vld (s_axis_tvalid),
        .o_item_rdy (s_axis_tready),
        .i_item     (item),
        .i_size     (r_palette_size),
        .i_out_free (out_free),
        .o_res      (res)
    );

    // Output register
    assign out_free = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res.vld) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.vld) begin
            r_out_idx <= res.idx;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_idx;

endmodule

// ----- design/npc_palette_ram.sv -----
// ----------------------------------------------------------------------------
// npc_palette_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module npc_palette_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/npc_dist.sv -----
// ----------------------------------------------------------------------------
// npc_dist
// Squared RGB distance between a palette word and the pixel, registered.
// ----------------------------------------------------------------------------
module npc_dist (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  npc_pkg::t_addr    i_idx,
    input  npc_pkg::t_word    i_word,
    input  npc_pkg::t_chan    i_red,
    input  npc_pkg::t_chan    i_green,
    input  npc_pkg::t_chan    i_blue,
    output npc_pkg::t_dist_res o_res
);

    npc_pkg::t_chan   d_red, d_green, d_blue;
    logic [15:0]      sq_red, sq_green, sq_blue;
    npc_pkg::t_dist   n_dist;
    npc_pkg::t_dist_res r_res;

    // Absolute channel differences; palette word is red, green, blue from top
    always_comb begin
        npc_pkg::t_chan w_red, w_green, w_blue;
        w_red   = i_word[3*npc_pkg::CHAN_W-1 -: npc_pkg::CHAN_W];
        w_green = i_word[2*npc_pkg::CHAN_W-1 -: npc_pkg::CHAN_W];
        w_blue  = i_word[npc_pkg::CHAN_W-1:0];
        d_red   = (w_red   > i_red)   ? (w_red   - i_red)   : (i_red   - w_red);
        d_green = (w_green > i_green) ? (w_green - i_green) : (i_green - w_green);
        d_blue  = (w_blue  > i_blue)  ? (w_blue  - i_blue)  : (i_blue  - w_blue);
    end

    // Three narrow squares and their sum
    assign sq_red   = 16'(d_red) * 16'(d_red);
    assign sq_green = 16'(d_green) * 16'(d_green);
    assign sq_blue  = 16'(d_blue) * 16'(d_blue);
    assign n_dist   = npc_pkg::t_dist'(sq_red) + npc_pkg::t_dist'(sq_green)
                    + npc_pkg::t_dist'(sq_blue);

    // Control bit under reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.vld <= 1'b0;
        end else begin
            r_res.vld <= i_vld;
        end
        r_res.idx      <= i_idx;
        r_res.distance <= n_dist;
    end

    assign o_res = r_res;

endmodule

// ----- design/npc_search.sv -----
// ----------------------------------------------------------------------------
// npc_search
// Palette store and scan sequencer: one entry read per cycle, best kept.
// ----------------------------------------------------------------------------
module npc_search (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_vld,
    output logic             o_item_rdy,
    input  npc_pkg::t_item   i_item,
    input  npc_pkg::t_size   i_size,
    input  logic             i_out_free,
    output npc_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state               r_state, n_state;
    npc_pkg::t_cnt        r_count, n_count;
    npc_pkg::t_cnt        r_issue, n_issue;
    logic                 r_rd_vld;
    npc_pkg::t_addr       r_rd_idx;
    npc_pkg::t_chan       r_red, r_green, r_blue;
    npc_pkg::t_dist       r_best_dist, n_best_dist;
    npc_pkg::t_addr       r_best_idx, n_best_idx;

    logic                 item_acc;
    logic                 wr_en;
    logic                 rd_en;
    npc_pkg::t_word       rd_data;
    npc_pkg::t_word       wr_data;
    npc_pkg::t_dist_res   dist_res;
    logic                 cmp_vld, better, last, hit;
    npc_pkg::t_cnt        size_sat;

    assign o_item_rdy = (r_state == ST_IDLE);
    assign item_acc   = i_item_vld && o_item_rdy;

    // Loads only happen in idle and reads only in scan, so the two ports
    // never touch the same entry in one cycle: no forwarding needed.
    assign wr_en   = item_acc && (i_item.cmd == npc_pkg::CMD_LOAD)
                  && (npc_pkg::t_size'(i_item.entry)
                      < npc_pkg::t_size'(npc_pkg::PALETTE_DEPTH));
    assign wr_data = {i_item.red, i_item.green, i_item.blue};
    assign rd_en   = (r_state == ST_SCAN) && (r_issue < r_count);

    // Palette size saturated to the store depth
    assign size_sat = (i_size > npc_pkg::t_size'(npc_pkg::PALETTE_DEPTH))
                    ? npc_pkg::t_cnt'(npc_pkg::PALETTE_DEPTH)
                    : i_size[npc_pkg::CNT_W-1:0];

    npc_palette_ram #(
        .DEPTH (npc_pkg::PALETTE_DEPTH),
        .WIDTH (npc_pkg::WORD_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_item.entry[npc_pkg::ADDR_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue[npc_pkg::ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    npc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld && (r_state == ST_SCAN)),
        .i_idx   (r_rd_idx),
        .i_word  (rd_data),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_res   (dist_res)
    );

    // Compare stage; anything still in flight after the scan is dropped
    assign cmp_vld = dist_res.vld && (r_state == ST_SCAN);
    assign better  = cmp_vld && (dist_res.distance < r_best_dist);
    assign hit     = better && (dist_res.distance == '0);
    assign last    = cmp_vld
                  && (npc_pkg::t_cnt'(dist_res.idx) == npc_pkg::t_cnt'(r_count - 1'b1));

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_best_dist = r_best_dist;
        n_best_idx  = r_best_idx;
        case (r_state)
            ST_IDLE: begin
                if (item_acc && (i_item.cmd == npc_pkg::CMD_PIXEL)) begin
                    n_count     = size_sat;
                    n_issue     = '0;
                    n_best_dist = npc_pkg::DIST_START;
                    n_best_idx  = '0;
                    n_state     = (size_sat == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    n_issue = r_issue + 1'b1;
                end
                if (better) begin
                    n_best_dist = dist_res.distance;
                    n_best_idx  = dist_res.idx;
                end
                if (last || hit) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_issue  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_issue  <= n_issue;
            r_rd_vld <= rd_en;
        end
    end

    // Pixel, read index and best-so-far
    always_ff @(posedge i_clk) begin
        r_rd_idx    <= r_issue[npc_pkg::ADDR_W-1:0];
        r_best_dist <= n_best_dist;
        r_best_idx  <= n_best_idx;
        if (item_acc) begin
            r_red   <= i_item.red;
            r_green <= i_item.green;
            r_blue  <= i_item.blue;
        end
    end

    assign o_res.vld = (r_state == ST_DONE) && i_out_free;
    assign o_res.idx = npc_pkg::t_idx'(r_best_idx);

`ifndef NO_ASSERTIONS
    // Read issue never runs past the saturated palette size
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue <= r_count)
        else $error("scan issued beyond palette size");

    // Best distance only improves while scanning
    a_best_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && $past(r_state == ST_SCAN) |->
            r_best_dist <= $past(r_best_dist))
        else $error("best distance grew during scan");

    // A delivered index lies inside the searched range
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.vld && (r_count != '0) |-> npc_pkg::t_cnt'(r_best_idx) < r_count)
        else $error("result index outside palette");

    // Palette port never written and read in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("palette write during scan");
`endif

endmodule
